@@ sv/stli_pkg.sv @@
package stli_pkg;

   // Field widths of the request and result.
   localparam int POS_W = 24;
   localparam int VAL_W = 16;
   localparam int TYPE_W = 2;
   localparam int STATUS_W = 2;

   // One table entry holds a position over a value.
   localparam int ENTRY_W = POS_W + VAL_W;

   // Product of a value difference and a position difference.
   localparam int PROD_W = POS_W + VAL_W;

   // The quotient never exceeds the value range, so the divider makes VAL_W bits.
   localparam int DIV_CNT_W = $clog2(VAL_W);

   // Request codes.
   localparam logic [TYPE_W-1:0] REQ_CLEAR  = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_APPEND = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_QUERY  = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // Query sequencer states.
   typedef enum logic [9:0] {
      S_IDLE      = 10'b00_0000_0001,
      S_CHK_FIRST = 10'b00_0000_0010,
      S_CHK_LAST  = 10'b00_0000_0100,
      S_SEARCH    = 10'b00_0000_1000,
      S_CMP       = 10'b00_0001_0000,
      S_RD_LO     = 10'b00_0010_0000,
      S_RD_HI     = 10'b00_0100_0000,
      S_MUL       = 10'b00_1000_0000,
      S_DIV       = 10'b01_0000_0000,
      S_FIN       = 10'b10_0000_0000
   } state_type;

endpackage

@@ sv/stli_ram.sv @@
module stli_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one read port with a registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/sorted_table_linear_interp_core.sv @@
// Breakpoint table with piecewise-linear lookup.
//
// A request is taken at a rising edge where start is high and busy is low.
// Clear empties the table, append stores one (position, value) breakpoint at
// the end of the table, and query returns the value interpolated at a
// position. Every request gives exactly one result, shown on the rsp_ ports
// for one cycle with rsp_strobe high; the receiver takes it at the edge that
// ends that cycle and cannot hold it off.
//
// Clear, append, unknown requests and queries on an empty table answer in
// the cycle after the request with busy low, so one can be taken every cycle.
// Other queries keep busy high while the first and last entries are
// checked, binary-search probes (at most ceil(log2(MAX_POINTS))) use the
// single read port of the table memory, the interval's breakpoints are read
// and the divider makes one quotient bit per cycle; a zero-length interval
// ends after the breakpoint reads, and a query at or beyond an end after the
// end checks. The result is shown in the first cycle with busy low again.
//
// Reset empties the table and returns the sequencer to idle. The memory is
// not cleared: only entries below the fill count are ever read.
module sorted_table_linear_interp_core
   import stli_pkg::*;
#(
   parameter int MAX_POINTS = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [TYPE_W-1:0]   req_type,
   input  logic [POS_W-1:0]    req_point_pos,
   input  logic [VAL_W-1:0]    req_point_value,
   input  logic [POS_W-1:0]    req_query_pos,
   output logic                rsp_strobe,
   output logic [VAL_W-1:0]    rsp_interp_value,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   // Control state.
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   // Payload registers.
   logic [POS_W-1:0]     query_ff, query_in;
   logic [CNT_W-1:0]     lo_ff, lo_in;
   logic [CNT_W-1:0]     hi_ff, hi_in;
   logic [CNT_W-1:0]     mid_ff, mid_in;
   logic [POS_W-1:0]     p1_ff, p1_in;
   logic [VAL_W-1:0]     v1_ff, v1_in;
   logic [VAL_W-1:0]     v2_ff, v2_in;
   logic [VAL_W-1:0]     dv_ff, dv_in;
   logic [POS_W-1:0]     dp_ff, dp_in;
   logic [POS_W-1:0]     den_ff, den_in;
   logic                 neg_ff, neg_in;
   logic [POS_W-1:0]     rem_ff, rem_in;
   logic [VAL_W-1:0]     quo_ff, quo_in;
   logic [VAL_W-1:0]     rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   // Memory ports.
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [ENTRY_W-1:0]   wr_data;
   logic [ADDR_W-1:0]    rd_addr;
   logic [ENTRY_W-1:0]   rd_data;
   logic [POS_W-1:0]     rd_pos;
   logic [VAL_W-1:0]     rd_val;

   // Datapath helpers.
   logic                 accept;
   logic                 full;
   logic [CNT_W-1:0]     last_idx;
   logic [CNT_W:0]       mid_sum;
   logic [CNT_W-1:0]     mid_w;
   logic                 more_probes;
   logic [CNT_W-1:0]     hi_clamped;
   logic [PROD_W-1:0]    product;
   logic [POS_W:0]       trial;
   logic                 trial_ge;
   logic [VAL_W+1:0]     sum;
   logic [VAL_W-1:0]     clamped;

   assign accept = start && !busy;
   assign full = (count_ff == CNT_W'(MAX_POINTS));
   assign last_idx = count_ff - CNT_W'(1);
   assign rd_pos = rd_data[ENTRY_W-1:VAL_W];
   assign rd_val = rd_data[VAL_W-1:0];

   // Appends are written only while idle and reads happen only during a
   // query, so the two ports never touch the same entry in one cycle.
   assign wr_en = accept && (req_type == REQ_APPEND) && !full;
   assign wr_addr = count_ff[ADDR_W-1:0];
   assign wr_data = {req_point_pos, req_point_value};

   // Binary-search bookkeeping.
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_w = mid_sum[CNT_W:1];
   assign more_probes = ({1'b0, lo_ff} + (CNT_W + 1)'(1)) < {1'b0, hi_ff};
   assign hi_clamped = (hi_ff >= count_ff) ? last_idx : hi_ff;

   // One restoring division step: shift in the next dividend bit and subtract.
   assign product = {{POS_W{1'b0}}, dv_ff} * {{VAL_W{1'b0}}, dp_ff};
   assign trial = {rem_ff, quo_ff[VAL_W-1]};
   assign trial_ge = (trial >= {1'b0, den_ff});

   // Signed result v2 +/- quotient, saturated to the value range.
   assign sum = neg_ff ? ({2'b00, v2_ff} - {2'b00, quo_ff})
                       : ({2'b00, v2_ff} + {2'b00, quo_ff});
   assign clamped = sum[VAL_W+1] ? '0 : (sum[VAL_W] ? '1 : sum[VAL_W-1:0]);

   stli_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_POINTS)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Sequencer and datapath next-state logic.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      rsp_strobe_in = 1'b0;
      div_cnt_in = div_cnt_ff;
      query_in = query_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      mid_in = mid_ff;
      p1_in = p1_ff;
      v1_in = v1_ff;
      v2_in = v2_ff;
      dv_in = dv_ff;
      dp_in = dp_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      rsp_value_in = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rd_addr = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               query_in = req_query_pos;
               rsp_value_in = '0;
               rsp_status_in = ST_OK;
               rsp_strobe_in = 1'b1;
               case (req_type)
                  REQ_CLEAR: begin
                     count_in = '0;
                  end
                  REQ_APPEND: begin
                     if (full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  REQ_QUERY: begin
                     if (count_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        // The first entry is read now and checked next cycle.
                        rsp_strobe_in = 1'b0;
                        state_in = S_CHK_FIRST;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // At or below the first point the first value is returned.
         S_CHK_FIRST: begin
            rd_addr = last_idx[ADDR_W-1:0];
            if (query_ff <= rd_pos) begin
               rsp_value_in = rd_val;
               rsp_strobe_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_CHK_LAST;
            end
         end

         // At or above the last point the last value is returned.
         S_CHK_LAST: begin
            if (query_ff >= rd_pos) begin
               rsp_value_in = rd_val;
               rsp_strobe_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               lo_in = '0;
               hi_in = count_ff;
               state_in = S_SEARCH;
            end
         end

         // Issue a probe at the midpoint, or read the lower end when done.
         S_SEARCH: begin
            if (more_probes) begin
               rd_addr = mid_w[ADDR_W-1:0];
               mid_in = mid_w;
               state_in = S_CMP;
            end else begin
               rd_addr = lo_ff[ADDR_W-1:0];
               hi_in = hi_clamped;
               state_in = S_RD_LO;
            end
         end

         // Narrow the interval with the probed position.
         S_CMP: begin
            if (rd_pos <= query_ff) begin
               lo_in = mid_ff;
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_SEARCH;
         end

         // Capture the lower breakpoint and read the upper one.
         S_RD_LO: begin
            rd_addr = hi_ff[ADDR_W-1:0];
            p1_in = rd_pos;
            v1_in = rd_val;
            state_in = S_RD_HI;
         end

         // Set up magnitudes; a zero-length or reversed interval returns the upper value.
         S_RD_HI: begin
            v2_in = rd_val;
            if (rd_pos <= p1_ff) begin
               rsp_value_in = rd_val;
               rsp_strobe_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               neg_in = (v1_ff < rd_val);
               dv_in = (v1_ff < rd_val) ? (rd_val - v1_ff) : (v1_ff - rd_val);
               dp_in = rd_pos - query_ff;
               den_in = rd_pos - p1_ff;
               state_in = S_MUL;
            end
         end

         // The lower breakpoint never lies above the query, so the quotient
         // fits in VAL_W bits and the high product bits start below den.
         S_MUL: begin
            rem_in = product[PROD_W-1:VAL_W];
            quo_in = product[VAL_W-1:0];
            div_cnt_in = '0;
            state_in = S_DIV;
         end

         // One quotient bit per cycle, shifted in where dividend bits leave.
         S_DIV: begin
            if (trial_ge) begin
               rem_in = trial[POS_W-1:0] - den_ff;
            end else begin
               rem_in = trial[POS_W-1:0];
            end
            quo_in = {quo_ff[VAL_W-2:0], trial_ge};
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_CNT_W'(VAL_W - 1)) begin
               state_in = S_FIN;
            end
         end

         // Apply the sign, saturate and deliver.
         S_FIN: begin
            rsp_value_in = clamped;
            rsp_strobe_in = 1'b1;
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_strobe_ff <= 1'b0;
         div_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      query_ff <= query_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      mid_ff <= mid_in;
      p1_ff <= p1_in;
      v1_ff <= v1_in;
      v2_ff <= v2_in;
      dv_ff <= dv_in;
      dp_ff <= dp_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      rsp_value_ff <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_interp_value = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

@@ sv/stli_checker.sv @@
module stli_checker
   import stli_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic [TYPE_W-1:0]   req_type,
   input logic                rsp_strobe,
   input logic [VAL_W-1:0]    rsp_interp_value,
   input logic [STATUS_W-1:0] rsp_status
);

   // Reset leaves the block idle with no result pending.
   assert property (@(posedge clock) reset |=> !busy && !rsp_strobe)
      else $error("block not idle after reset");

   // Requests other than a query answer in the very next cycle.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_type != REQ_QUERY) |=> rsp_strobe)
      else $error("non-query request did not answer in the next cycle");

   // A query either answers at once or keeps the block busy.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_type == REQ_QUERY) |=> rsp_strobe || busy)
      else $error("query request lost");

   // A result is only shown once the sequencer has finished.
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> !busy)
      else $error("result shown while busy");

   // An empty or full status carries a zero value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status != ST_OK) |-> (rsp_interp_value == '0))
      else $error("nonzero value with error status");

endmodule

bind sorted_table_linear_interp_core stli_checker u_stli_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_type        (req_type),
   .rsp_strobe      (rsp_strobe),
   .rsp_interp_value(rsp_interp_value),
   .rsp_status      (rsp_status)
);

@@ bench/tb_sorted_table_linear_interp_core.sv @@
`timescale 1ns / 100ps

module tb_sorted_table_linear_interp_core;
   import stli_pkg::*;

   localparam int TABLE_DEPTH = 256;
   localparam logic [TYPE_W-1:0] REQ_UNKNOWN = 2'd3;
   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
   localparam int REQUEST_TARGET = 1200;
   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 64;

   typedef struct packed {
      logic [TYPE_W-1:0] kind;
      logic [POS_W-1:0]  point_pos;
      logic [VAL_W-1:0]  point_value;
      logic [POS_W-1:0]  query_pos;
   } request_type;

   typedef struct packed {
      logic [VAL_W-1:0]    value;
      logic [STATUS_W-1:0] status;
   } result_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [TYPE_W-1:0]   req_type = REQ_CLEAR;
   logic [POS_W-1:0]    req_point_pos = '0;
   logic [VAL_W-1:0]    req_point_value = '0;
   logic [POS_W-1:0]    req_query_pos = '0;
   logic                rsp_strobe;
   logic [VAL_W-1:0]    rsp_interp_value;
   logic [STATUS_W-1:0] rsp_status;

   sorted_table_linear_interp_core #(
      .MAX_POINTS(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_point_pos(req_point_pos),
      .req_point_value(req_point_value),
      .req_query_pos(req_query_pos),
      .rsp_strobe(rsp_strobe),
      .rsp_interp_value(rsp_interp_value),
      .rsp_status(rsp_status)
   );

   // Requests waiting to be driven, and results the block still owes.
   request_type request_backlog[$];
   result_type  owed_results[$];

   int accept_count = 0;
   int issue_count = 0;
   int mismatch_count = 0;
   int idle_cycles = 0;
   int gap_left = 0;
   int burst_left = 0;
   int counted_requests = 0;

   // Tallies for the closing summary.
   int interp_count = 0;
   int append_count = 0;
   int drop_count = 0;
   int empty_count = 0;
   int clear_count = 0;
   int unknown_count = 0;

   // Shadow of the breakpoint table.
   logic [POS_W-1:0] pos_tab [TABLE_DEPTH];
   logic [VAL_W-1:0] val_tab [TABLE_DEPTH];
   int unsigned      fill_count = 0;

   // Positions of the table the stimulus is currently building.
   logic [POS_W-1:0] built_pos[$];

   // The clock runs with an 8 ns period.
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // End checks first, then a binary search for the enclosing interval and a truncating interpolation, saturated.
   function automatic logic [VAL_W-1:0] interpolate_at(logic [POS_W-1:0] q);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      longint p1;
      longint p2;
      longint v1;
      longint v2;
      longint qv;
      longint span;
      longint r;
      if (q <= pos_tab[0]) return val_tab[0];
      if (q >= pos_tab[fill_count - 1]) return val_tab[fill_count - 1];
      lo = 0;
      hi = fill_count;
      while (lo + 1 < hi) begin
         mid = (lo + hi) / 2;
         if (pos_tab[mid] <= q) begin
            lo = mid;
         end else begin
            hi = mid;
         end
      end
      if (hi >= fill_count) hi = fill_count - 1;
      p1 = pos_tab[lo];
      p2 = pos_tab[hi];
      v1 = val_tab[lo];
      v2 = val_tab[hi];
      qv = q;
      span = p2 - p1;
      // A zero-length or reversed interval takes the upper value.
      if (span <= 0) return VAL_W'(v2);
      r = v2 + (v1 - v2) * (p2 - qv) / span;
      if (r < 0) r = 0;
      if (r > 65535) r = 65535;
      return VAL_W'(r);
   endfunction

   // Applies one accepted request to the shadow table and returns its result.
   function automatic result_type apply_request(request_type r);
      result_type res;
      res.value = '0;
      res.status = ST_OK;
      case (r.kind)
         REQ_CLEAR: begin
            fill_count = 0;
            clear_count++;
         end
         REQ_APPEND: begin
            if (fill_count >= TABLE_DEPTH) begin
               res.status = ST_FULL;
               drop_count++;
            end else begin
               pos_tab[fill_count] = r.point_pos;
               val_tab[fill_count] = r.point_value;
               fill_count++;
               append_count++;
            end
         end
         REQ_QUERY: begin
            if (fill_count == 0) begin
               res.status = ST_EMPTY;
               empty_count++;
            end else begin
               res.value = interpolate_at(r.query_pos);
               interp_count++;
            end
         end
         default: begin
            unknown_count++;
         end
      endcase
      return res;
   endfunction

   function automatic logic [POS_W-1:0] any_pos();
      return POS_W'($urandom);
   endfunction

   function automatic logic [VAL_W-1:0] any_val();
      return VAL_W'($urandom);
   endfunction

   task automatic add_request(input logic [TYPE_W-1:0] kind, input logic [POS_W-1:0] ppos,
                              input logic [VAL_W-1:0] pval, input logic [POS_W-1:0] qpos);
      request_type r;
      r.kind = kind;
      r.point_pos = ppos;
      r.point_value = pval;
      r.query_pos = qpos;
      request_backlog.push_back(r);
      if (kind != REQ_UNKNOWN) counted_requests++;
   endtask

   // Clears the table and appends a nondecreasing run of breakpoints.
   task automatic add_sorted_table(input int points, input bit wide, input int unsigned step);
      longint unsigned pos;
      int unsigned step_max;
      pos = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 255)
                                        : $urandom_range(0, POS_MAX / 2);
      step_max = wide ? 32'((POS_MAX - pos) / points) : step;
      built_pos.delete();
      add_request(REQ_CLEAR, any_pos(), any_val(), any_pos());
      for (int i = 0; i < points; i++) begin
         if (i > 0) pos += $urandom_range(0, step_max);
         if (pos > POS_MAX) pos = POS_MAX;
         add_request(REQ_APPEND, POS_W'(pos), any_val(), any_pos());
         if (i < TABLE_DEPTH) built_pos.push_back(POS_W'(pos));
      end
   endtask

   // Queries into the table just built: inside, on points, past either end and anywhere.
   task automatic add_queries(input int count);
      logic [POS_W-1:0] lo_pos;
      logic [POS_W-1:0] hi_pos;
      logic [POS_W-1:0] q;
      int pick;
      lo_pos = built_pos[0];
      hi_pos = built_pos[built_pos.size() - 1];
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            q = POS_W'($urandom_range(lo_pos, hi_pos));
         end else if (pick < 75) begin
            q = built_pos[$urandom_range(0, built_pos.size() - 1)];
         end else if (pick < 85) begin
            q = POS_W'($urandom_range(0, lo_pos));
         end else if (pick < 95) begin
            q = POS_W'($urandom_range(hi_pos, POS_MAX));
         end else begin
            q = any_pos();
         end
         add_request(REQ_QUERY, any_pos(), any_val(), q);
      end
   endtask

   // Arbitrary requests: unsorted appends, stray clears, queries, unknown codes.
   task automatic add_noise(input int count);
      for (int i = 0; i < count; i++) begin
         add_request(TYPE_W'($urandom_range(0, 3)), any_pos(), any_val(), any_pos());
      end
   endtask

   task automatic build_stimulus();
      int roll;
      int points;
      // Directed: empty table, unknown code, single point, extremes, unsorted append.
      add_request(REQ_QUERY, '0, '0, '0);
      add_request(REQ_UNKNOWN, POS_MAX, 16'hFFFF, POS_MAX);
      add_request(REQ_APPEND, 24'h000000, 16'hFFFF, '0);
      add_request(REQ_QUERY, '0, '0, 24'h000000);
      add_request(REQ_QUERY, '0, '0, POS_MAX);
      add_request(REQ_APPEND, 24'h000100, 16'h0000, '0);
      add_request(REQ_APPEND, 24'h000100, 16'h1234, '0);
      add_request(REQ_APPEND, 24'h800000, 16'h8000, '0);
      add_request(REQ_APPEND, POS_MAX, 16'h0001, '0);
      add_request(REQ_QUERY, '0, '0, 24'h000080);
      add_request(REQ_QUERY, '0, '0, 24'h000100);
      add_request(REQ_QUERY, '0, '0, 24'h400000);
      add_request(REQ_QUERY, '0, '0, 24'h800000);
      add_request(REQ_QUERY, '0, '0, 24'hFFFFFE);
      add_request(REQ_QUERY, '0, '0, POS_MAX);
      add_request(REQ_APPEND, 24'h000200, 16'hFFFF, '0);
      add_request(REQ_QUERY, '0, '0, 24'h000180);
      add_request(REQ_QUERY, '0, '0, 24'h7FFFFF);
      add_request(REQ_CLEAR, POS_MAX, 16'hFFFF, POS_MAX);
      add_request(REQ_QUERY, '0, '0, 24'h123456);
      add_request(REQ_APPEND, 24'hABCDEF, 16'h5555, '0);
      add_request(REQ_QUERY, '0, '0, 24'h000000);
      add_request(REQ_QUERY, '0, '0, 24'hABCDEF);

      // One table filled past its depth so appends get dropped.
      add_sorted_table(TABLE_DEPTH + 4, 1'b1, 0);
      add_queries(12);

      // Random tables followed by queries, mixed with noise.
      while (counted_requests < REQUEST_TARGET) begin
         roll = $urandom_range(0, 99);
         if (roll < 20) begin
            add_noise($urandom_range(1, 6));
         end else begin
            if (roll < 21) begin
               points = $urandom_range(TABLE_DEPTH - 8, TABLE_DEPTH + 3);
            end else if (roll < 30) begin
               points = $urandom_range(13, 40);
            end else begin
               points = $urandom_range(1, 12);
            end
            case ($urandom_range(0, 2))
               0: add_sorted_table(points, 1'b1, 0);
               1: add_sorted_table(points, 1'b0, 3);
               default: add_sorted_table(points, 1'b0, 400);
            endcase
            add_queries($urandom_range(3, 10));
         end
      end
   endtask

   // Driver: puts the next request up at the falling edge, with random gaps.
   always @(negedge clock) begin
      request_type next_req;
      if (reset) begin
         start <= 1'b0;
      end else if (start && accept_count != issue_count) begin
         // The block has not taken the current request yet.
      end else if (gap_left > 0) begin
         start <= 1'b0;
         if (!busy) gap_left--;
      end else if (request_backlog.size() > 0) begin
         next_req = request_backlog.pop_front();
         req_type <= next_req.kind;
         req_point_pos <= next_req.point_pos;
         req_point_value <= next_req.point_value;
         req_query_pos <= next_req.query_pos;
         start <= 1'b1;
         issue_count++;
         if (burst_left > 0) begin
            burst_left--;
            gap_left = 0;
         end else begin
            gap_left = $urandom_range(0, 3);
            if ($urandom_range(0, 63) == 0) burst_left = $urandom_range(20, 60);
         end
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor: checks results, records accepted requests and guards against hangs.
   always @(posedge clock) begin
      result_type want;
      request_type taken;
      logic progress;
      progress = 1'b0;
      if (!reset) begin
         if (rsp_strobe) begin
            progress = 1'b1;
            if (owed_results.size() == 0) begin
               $display("%0t: result with nothing expected: value %h, status %0d",
                        $time, rsp_interp_value, rsp_status);
               mismatch_count++;
            end else begin
               want = owed_results.pop_front();
               if (rsp_interp_value !== want.value) begin
                  $display("%0t: interp_value expected %h, actual %h",
                           $time, want.value, rsp_interp_value);
                  mismatch_count++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d, actual %0d",
                           $time, want.status, rsp_status);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) begin
            progress = 1'b1;
            taken.kind = req_type;
            taken.point_pos = req_point_pos;
            taken.point_value = req_point_value;
            taken.query_pos = req_query_pos;
            owed_results.push_back(apply_request(taken));
            accept_count++;
         end
         if (progress) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("%0t: timeout, nothing moved for %0d cycles", $time, IDLE_LIMIT);
               $display("FAILED: results differ");
               $finish;
            end
         end
      end
   end

   // Reset, then wait for every request and result before the verdict.
   initial begin
      build_stimulus();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (request_backlog.size() > 0 || accept_count != issue_count
             || owed_results.size() > 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Ran %0d requests: %0d interpolations, %0d empty-table queries, %0d clears.",
               accept_count, interp_count, empty_count, clear_count);
      $display("Appends: %0d stored, %0d dropped on a full table; %0d unknown codes.",
               append_count, drop_count, unknown_count);
      if (mismatch_count == 0 && owed_results.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/stli_pkg.sv
sv/stli_ram.sv
sv/sorted_table_linear_interp_core.sv
sv/stli_checker.sv
bench/tb_sorted_table_linear_interp_core.sv
